// ----- design/rch_pkg.sv -----
package rch_pkg;

	// Input coordinate width and fraction bits of the distance.
	localparam int COORD_BITS    = 12;
	localparam int FRACTION_BITS = 4;
	localparam int OUT_BITS      = 18;

	// Box ends and axis gaps: a far edge is left + width, one bit wider.
	localparam int EXT_BITS = COORD_BITS + 1;
	localparam int SQ_BITS  = 2 * EXT_BITS;
	localparam int SUM_BITS = SQ_BITS + 1;

	// Radicand is the squared distance scaled by 2^(2*FRACTION_BITS), padded to even.
	localparam int RAD_BITS  = ((SUM_BITS + 2 * FRACTION_BITS + 1) / 2) * 2;
	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 2;

	// Square root resolves SQRT_STEP result bits per pipeline stage.
	localparam int SQRT_STEP   = 2;
	localparam int SQRT_STAGES = (ROOT_BITS + SQRT_STEP - 1) / SQRT_STEP;

	// Stages of the corner distance front end, and total latency.
	localparam int FRONT_STAGES = 7;
	localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [EXT_BITS-1:0]   ext_t;
	typedef logic [SUM_BITS-1:0]   dsq_t;

	// Distance of a point to an interval along one axis; zero on or inside.
	function automatic ext_t axis_gap(input ext_t p, input ext_t lo, input ext_t hi);
		ext_t g;
		if (p < lo) begin
			g = lo - p;
		end else if (p > hi) begin
			g = p - hi;
		end else begin
			g = '0;
		end
		return g;
	endfunction

endpackage

// ----- design/rect_corner_hausdorff_distance.sv -----
// Pipeline: 7 front-end stages from the start transfer (box ends, gaps,
// squares, sums, minima and maximum), then 9 square root stages resolving
// two result bits each, up to the done strobe.
// Throughput: one box pair per cycle; busy is low except in the first cycle after reset.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module rect_corner_hausdorff_distance (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [rch_pkg::COORD_BITS-1:0]  first_left,
	input  logic [rch_pkg::COORD_BITS-1:0]  first_top,
	input  logic [rch_pkg::COORD_BITS-1:0]  first_width,
	input  logic [rch_pkg::COORD_BITS-1:0]  first_height,
	input  logic [rch_pkg::COORD_BITS-1:0]  second_left,
	input  logic [rch_pkg::COORD_BITS-1:0]  second_top,
	input  logic [rch_pkg::COORD_BITS-1:0]  second_width,
	input  logic [rch_pkg::COORD_BITS-1:0]  second_height,
	output logic                            done,
	output logic [rch_pkg::OUT_BITS-1:0]    distance_q4
);
	import rch_pkg::*;

	logic                 busy_q;
	logic                 in_xfer;
	coord_t               left   [2];
	coord_t               top    [2];
	coord_t               width  [2];
	coord_t               height [2];
	logic                 front_vld;
	dsq_t                 front_d2;
	logic                 root_vld;
	logic [ROOT_BITS-1:0] root;

	// Hold busy for one cycle after reset release, then drop it for good:
	// the pipeline never stalls, so every start is a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy    = busy_q;
	assign in_xfer = start && !busy_q;

	// Group both boxes so the front end can index by box.
	assign left[0]   = first_left;
	assign left[1]   = second_left;
	assign top[0]    = first_top;
	assign top[1]    = second_top;
	assign width[0]  = first_width;
	assign width[1]  = second_width;
	assign height[0] = first_height;
	assign height[1] = second_height;

	// Squared corner-to-box distances, min per direction, max of the two.
	rch_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_xfer),
		.left    (left),
		.top     (top),
		.width   (width),
		.height  (height),
		.out_vld (front_vld),
		.d2      (front_d2)
	);

	// Pipelined integer square root of the scaled squared distance.
	rch_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (front_vld),
		.d2      (front_d2),
		.out_vld (root_vld),
		.root    (root)
	);

	// The last root stage register is the output register.
	assign done        = root_vld;
	assign distance_q4 = OUT_BITS'(root);

	// Busy never rises again once it has dropped.
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

	// Every transfer yields a result after the front-end and square root stages.
	a_xfer_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after transfer");

	// Every result traces back to a transfer.
	a_result_has_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a transfer");

	// Front end and root stage hand over items in lockstep.
	a_front_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		front_vld |-> ##SQRT_STAGES root_vld)
		else $error("item lost between front end and square root");

endmodule

// ----- design/rch_front.sv -----
module rch_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  rch_pkg::coord_t left   [2],
	input  rch_pkg::coord_t top    [2],
	input  rch_pkg::coord_t width  [2],
	input  rch_pkg::coord_t height [2],
	output logic            out_vld,
	output rch_pkg::dsq_t   d2
);
	import rch_pkg::*;

	logic [FRONT_STAGES-1:0] vld_q;

	// Indexing: [box or direction][axis: 0 x, 1 y][near or far end]
	ext_t                lo_s1  [2][2];
	ext_t                hi_s1  [2][2];
	ext_t                gap_s2 [2][2][2];
	logic [SQ_BITS-1:0]  sq_s3  [2][2][2];
	dsq_t                sum_s4 [2][4];
	dsq_t                pm_s5  [2][2];
	dsq_t                dm_s6  [2];
	dsq_t                d2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		// Box ends; far edge inclusive for the gap test.
		for (int b = 0; b < 2; b++) begin
			lo_s1[b][0] <= EXT_BITS'(left[b]);
			lo_s1[b][1] <= EXT_BITS'(top[b]);
			hi_s1[b][0] <= EXT_BITS'(left[b]) + EXT_BITS'(width[b]);
			hi_s1[b][1] <= EXT_BITS'(top[b]) + EXT_BITS'(height[b]);
		end
		// Gaps of the corners of box d to box 1-d.
		for (int d = 0; d < 2; d++) begin
			for (int a = 0; a < 2; a++) begin
				gap_s2[d][a][0] <= axis_gap(lo_s1[d][a], lo_s1[1-d][a], hi_s1[1-d][a]);
				gap_s2[d][a][1] <= axis_gap(hi_s1[d][a], lo_s1[1-d][a], hi_s1[1-d][a]);
			end
		end
		for (int d = 0; d < 2; d++) begin
			for (int a = 0; a < 2; a++) begin
				for (int k = 0; k < 2; k++) begin
					sq_s3[d][a][k] <= SQ_BITS'(gap_s2[d][a][k]) * SQ_BITS'(gap_s2[d][a][k]);
				end
			end
		end
		// Corner c takes x end c[1] and y end c[0].
		for (int d = 0; d < 2; d++) begin
			for (int c = 0; c < 4; c++) begin
				sum_s4[d][c] <= SUM_BITS'(sq_s3[d][0][c/2]) + SUM_BITS'(sq_s3[d][1][c%2]);
			end
		end
		for (int d = 0; d < 2; d++) begin
			for (int h = 0; h < 2; h++) begin
				pm_s5[d][h] <= (sum_s4[d][2*h+1] < sum_s4[d][2*h]) ?
					sum_s4[d][2*h+1] : sum_s4[d][2*h];
			end
			dm_s6[d] <= (pm_s5[d][1] < pm_s5[d][0]) ? pm_s5[d][1] : pm_s5[d][0];
		end
		d2_s7 <= (dm_s6[1] > dm_s6[0]) ? dm_s6[1] : dm_s6[0];
	end

	assign out_vld = vld_q[FRONT_STAGES-1];
	assign d2      = d2_s7;

endmodule

// ----- design/rch_sqrt.sv -----
module rch_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  rch_pkg::dsq_t                  d2,
	output logic                           out_vld,
	output logic [rch_pkg::ROOT_BITS-1:0]  root
);
	import rch_pkg::*;

	logic [SQRT_STAGES-1:0] vld_q;
	logic [REM_BITS-1:0]    rem_s  [SQRT_STAGES];
	logic [ROOT_BITS-1:0]   root_s [SQRT_STAGES];
	logic [RAD_BITS-1:0]    rad_s  [SQRT_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[SQRT_STAGES-2:0], in_vld};
		end
	end

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		logic [REM_BITS-1:0]  rem_in;
		logic [ROOT_BITS-1:0] root_in;
		logic [RAD_BITS-1:0]  rad_in;
		logic [REM_BITS-1:0]  rem_nx;
		logic [ROOT_BITS-1:0] root_nx;
		logic [RAD_BITS-1:0]  rad_nx;
		logic [REM_BITS-1:0]  trial;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = RAD_BITS'(d2) << (2 * FRACTION_BITS);
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign rad_in  = rad_s[i-1];
		end

		// Bring down two radicand bits, try root*4+1, keep one result bit.
		always_comb begin
			rem_nx  = rem_in;
			root_nx = root_in;
			rad_nx  = rad_in;
			trial   = '0;
			for (int j = 0; j < SQRT_STEP; j++) begin
				if (i * SQRT_STEP + j < ROOT_BITS) begin
					rem_nx = {rem_nx[REM_BITS-3:0], rad_nx[RAD_BITS-1 -: 2]};
					rad_nx = rad_nx << 2;
					trial  = {root_nx, 2'b01};
					if (rem_nx >= trial) begin
						rem_nx  = rem_nx - trial;
						root_nx = {root_nx[ROOT_BITS-2:0], 1'b1};
					end else begin
						root_nx = {root_nx[ROOT_BITS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= rem_nx;
			root_s[i] <= root_nx;
			rad_s[i]  <= rad_nx;
		end
	end

	assign out_vld = vld_q[SQRT_STAGES-1];
	assign root    = root_s[SQRT_STAGES-1];

endmodule
